// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent on the same edge
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent on the next edge, reset included
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/trap_pkg.sv =====
// Package: widths, register indexes and pipeline depth of the pulse waveform block
`timescale 1ns / 1ps
package trap_pkg;
  localparam int TIME_BITS  = 32;
  localparam int LEVEL_BITS = 16;
  // magnitude of a level difference fits in LEVEL_BITS unsigned bits
  localparam int MAG_BITS   = LEVEL_BITS;
  localparam int PROD_BITS  = MAG_BITS + TIME_BITS;
  localparam int MOD_STAGES = TIME_BITS;
  localparam int DIV_STAGES = MAG_BITS;
  // input register, modulo steps, classify, multiply, divide steps, output register
  localparam int LATENCY    = MOD_STAGES + DIV_STAGES + 4;
  localparam int CFG_BITS   = TIME_BITS > LEVEL_BITS ? TIME_BITS : LEVEL_BITS;
  localparam int IDX_BITS   = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_INITIAL = 3'd0,
    REG_PULSE   = 3'd1,
    REG_DELAY   = 3'd2,
    REG_RISE    = 3'd3,
    REG_FALL    = 3'd4,
    REG_WIDTH   = 3'd5,
    REG_PERIOD  = 3'd6
  } cfg_idx_t;
endpackage

// ===== design/trapezoid_pulse_waveform_top.sv =====
// Top level: pipelined trapezoid pulse waveform generator
//
//  channel  ports                               direction
//  input    start, busy, in_time_ticks          in (busy out)
//  result   out_valid, out_level                out
//  config   cfg_we, cfg_index, cfg_data         in
//
// One word enters every cycle; busy is always low. Each result passes through the
// input register, the bit-per-stage modulo pipeline, the classify and multiply
// registers, the bit-per-stage ramp divider and the output register.
// Reset clears the valid bits and the registers; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module trapezoid_pulse_waveform_top
  import trap_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [TIME_BITS-1:0]         in_time_ticks,
  output logic                         out_valid,
  output logic signed [LEVEL_BITS-1:0] out_level,
  input  logic                         cfg_we,
  input  logic [IDX_BITS-1:0]          cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data
);

  logic signed [LEVEL_BITS-1:0] init_r, pulse_r;
  logic [TIME_BITS-1:0] delay_r, rise_r, fall_r, width_r, period_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= '0;
      pulse_r  <= '0;
      delay_r  <= '0;
      rise_r   <= '0;
      fall_r   <= '0;
      width_r  <= '0;
      period_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL: init_r   <= cfg_data[LEVEL_BITS-1:0];
        REG_PULSE:   pulse_r  <= cfg_data[LEVEL_BITS-1:0];
        REG_DELAY:   delay_r  <= cfg_data[TIME_BITS-1:0];
        REG_RISE:    rise_r   <= cfg_data[TIME_BITS-1:0];
        REG_FALL:    fall_r   <= cfg_data[TIME_BITS-1:0];
        REG_WIDTH:   width_r  <= cfg_data[TIME_BITS-1:0];
        REG_PERIOD:  period_r <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input stage: register the word
  logic                 s0_v_r;
  logic [TIME_BITS-1:0] s0_t_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else        s0_v_r <= start & ~busy;
  end
  always_ff @(posedge clk) begin
    s0_t_r <= in_time_ticks;
  end

  // Modulo pipeline: one dividend bit per stage
  logic                 mv_r   [MOD_STAGES];
  logic                 mb_r   [MOD_STAGES];
  logic [TIME_BITS-1:0] md_r   [MOD_STAGES];
  logic [TIME_BITS-1:0] mrem_r [MOD_STAGES];

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    logic                 v_in, b_in;
    logic [TIME_BITS-1:0] d_in, r_in, r_nxt;
    logic [TIME_BITS:0]   sh;
    if (k == 0) begin : g_first
      assign v_in = s0_v_r;
      assign b_in = s0_t_r < delay_r;
      assign d_in = s0_t_r - delay_r;
      assign r_in = '0;
    end else begin : g_rest
      assign v_in = mv_r[k-1];
      assign b_in = mb_r[k-1];
      assign d_in = md_r[k-1];
      assign r_in = mrem_r[k-1];
    end
    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      sh = {r_in, d_in[TIME_BITS-1-k]};
      if (sh >= {1'b0, period_r}) r_nxt = TIME_BITS'(sh - {1'b0, period_r});
      else                        r_nxt = sh[TIME_BITS-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) mv_r[k] <= 1'b0;
      else        mv_r[k] <= v_in;
    end
    always_ff @(posedge clk) begin
      mb_r[k]   <= b_in;
      md_r[k]   <= d_in;
      mrem_r[k] <= r_nxt;
    end
  end

  // Classify the phase and pick the ramp operands
  logic                         cv_r, cneg_r;
  logic signed [LEVEL_BITS-1:0] cfrom_r;
  logic [MAG_BITS-1:0]          cmag_r;
  logic [TIME_BITS-1:0]         cnum_r, cden_r;

  logic [TIME_BITS-1:0]         phase, num_c, den_c;
  logic [TIME_BITS:0]           top_end;
  logic [TIME_BITS+1:0]         fall_end;
  logic signed [LEVEL_BITS-1:0] from_c, to_c;
  logic signed [LEVEL_BITS:0]   diff;
  logic                         ramp_c;

  always_comb begin
    phase    = (period_r == '0) ? md_r[MOD_STAGES-1] : mrem_r[MOD_STAGES-1];
    top_end  = {1'b0, rise_r} + {1'b0, width_r};
    fall_end = {1'b0, top_end} + {2'b00, fall_r};
    from_c   = init_r;
    to_c     = init_r;
    num_c    = '0;
    // a nonzero divisor keeps the quotient at zero outside the ramps
    den_c    = TIME_BITS'(1);
    ramp_c   = 1'b0;
    priority if (mb_r[MOD_STAGES-1]) begin
      from_c = init_r;
    end else if (phase < rise_r) begin
      from_c = init_r;
      to_c   = pulse_r;
      num_c  = phase;
      den_c  = rise_r;
      ramp_c = 1'b1;
    end else if ({1'b0, phase} < top_end) begin
      from_c = pulse_r;
      to_c   = pulse_r;
    end else if ({2'b00, phase} < fall_end) begin
      from_c = pulse_r;
      to_c   = init_r;
      num_c  = TIME_BITS'({1'b0, phase} - top_end);
      den_c  = fall_r;
      ramp_c = 1'b1;
    end else begin
      from_c = init_r;
    end
    diff = (LEVEL_BITS+1)'(to_c) - (LEVEL_BITS+1)'(from_c);
    if (!ramp_c) diff = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= 1'b0;
    else        cv_r <= mv_r[MOD_STAGES-1];
  end
  always_ff @(posedge clk) begin
    cfrom_r <= from_c;
    cneg_r  <= diff[LEVEL_BITS];
    cmag_r  <= diff[LEVEL_BITS] ? MAG_BITS'(-diff) : diff[MAG_BITS-1:0];
    cnum_r  <= num_c;
    cden_r  <= den_c;
  end

  // Multiply magnitude by elapsed ticks
  logic                         pv_r, pneg_r;
  logic signed [LEVEL_BITS-1:0] pfrom_r;
  logic [PROD_BITS-1:0]         prod_r;
  logic [TIME_BITS-1:0]         pden_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= cv_r;
  end
  always_ff @(posedge clk) begin
    pfrom_r <= cfrom_r;
    pneg_r  <= cneg_r;
    prod_r  <= {{TIME_BITS{1'b0}}, cmag_r} * {{MAG_BITS{1'b0}}, cnum_r};
    pden_r  <= cden_r;
  end

  // Divide pipeline: quotient is below 2**MAG_BITS, one bit per stage
  logic                         dv_r   [DIV_STAGES];
  logic                         dneg_r [DIV_STAGES];
  logic signed [LEVEL_BITS-1:0] dfrom_r[DIV_STAGES];
  logic [TIME_BITS-1:0]         drem_r [DIV_STAGES];
  logic [MAG_BITS-1:0]          dlo_r  [DIV_STAGES];
  logic [MAG_BITS-1:0]          dq_r   [DIV_STAGES];
  logic [TIME_BITS-1:0]         dden_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic                         v_in, n_in;
    logic signed [LEVEL_BITS-1:0] f_in;
    logic [TIME_BITS-1:0]         r_in, den_in, r_nxt;
    logic [MAG_BITS-1:0]          lo_in, q_in;
    logic [TIME_BITS:0]           sh;
    logic                         qb;
    if (j == 0) begin : g_first
      assign v_in   = pv_r;
      assign n_in   = pneg_r;
      assign f_in   = pfrom_r;
      assign r_in   = prod_r[PROD_BITS-1:MAG_BITS];
      assign lo_in  = prod_r[MAG_BITS-1:0];
      assign q_in   = '0;
      assign den_in = pden_r;
    end else begin : g_rest
      assign v_in   = dv_r[j-1];
      assign n_in   = dneg_r[j-1];
      assign f_in   = dfrom_r[j-1];
      assign r_in   = drem_r[j-1];
      assign lo_in  = dlo_r[j-1];
      assign q_in   = dq_r[j-1];
      assign den_in = dden_r[j-1];
    end
    // shift in a product bit, subtract the duration when it fits
    always_comb begin
      sh = {r_in, lo_in[MAG_BITS-1-j]};
      qb = sh >= {1'b0, den_in};
      if (qb) r_nxt = TIME_BITS'(sh - {1'b0, den_in});
      else    r_nxt = sh[TIME_BITS-1:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[j] <= 1'b0;
      else        dv_r[j] <= v_in;
    end
    always_ff @(posedge clk) begin
      dneg_r[j]  <= n_in;
      dfrom_r[j] <= f_in;
      drem_r[j]  <= r_nxt;
      dlo_r[j]   <= lo_in;
      dq_r[j]    <= {q_in[MAG_BITS-2:0], qb};
      dden_r[j]  <= den_in;
    end
  end

  // Output stage: apply the ramp step to the start level
  logic [LEVEL_BITS:0] lvl_c;
  always_comb begin
    if (dneg_r[DIV_STAGES-1])
      lvl_c = (LEVEL_BITS+1)'(dfrom_r[DIV_STAGES-1]) - {1'b0, dq_r[DIV_STAGES-1]};
    else
      lvl_c = (LEVEL_BITS+1)'(dfrom_r[DIV_STAGES-1]) + {1'b0, dq_r[DIV_STAGES-1]};
  end

  logic                         ov_r;
  logic signed [LEVEL_BITS-1:0] olvl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= dv_r[DIV_STAGES-1];
  end
  always_ff @(posedge clk) begin
    olvl_r <= lvl_c[LEVEL_BITS-1:0];
  end

  assign out_valid = ov_r;
  assign out_level = olvl_r;

endmodule

// ===== design/trap_checker.sv =====
// Port checker for the pulse waveform block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trap_checker
  import trap_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic signed [LEVEL_BITS-1:0] out_level
);

  // a result only leaves for a word taken a fixed latency earlier
  `ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, LATENCY))
  // the block takes a word every cycle
  `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  // reset drops the result strobe
  `ASSERT_NEXT(a_reset_clears, clk, !rst_n, !out_valid)
  // a result strobe never shows an unknown level
  `ASSERT_IMPLY(a_level_known, clk, rst_n, out_valid, !$isunknown(out_level))

endmodule

bind trapezoid_pulse_waveform_top trap_checker u_trap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_level (out_level)
);

// ===== test/tb_top.sv =====
// Testbench for the trapezoid pulse waveform generator, with a scoreboard and drive tasks
`timescale 1ns / 1ps
module tb_top;
  import trap_pkg::*;

  localparam logic [IDX_BITS-1:0] IDX_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  // Expected levels, with a private copy of the level and timing registers
  class level_scoreboard;
    logic signed [LEVEL_BITS-1:0] init_lvl = '0;
    logic signed [LEVEL_BITS-1:0] pulse_lvl = '0;
    logic [TIME_BITS-1:0] dly = '0;
    logic [TIME_BITS-1:0] rise = '0;
    logic [TIME_BITS-1:0] fall = '0;
    logic [TIME_BITS-1:0] wid = '0;
    logic [TIME_BITS-1:0] per = '0;
    logic signed [LEVEL_BITS-1:0] expected_levels[$];
    int errors, results, words;

    function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_INITIAL: init_lvl = data[LEVEL_BITS-1:0];
        REG_PULSE:   pulse_lvl = data[LEVEL_BITS-1:0];
        REG_DELAY:   dly = data[TIME_BITS-1:0];
        REG_RISE:    rise = data[TIME_BITS-1:0];
        REG_FALL:    fall = data[TIME_BITS-1:0];
        REG_WIDTH:   wid = data[TIME_BITS-1:0];
        REG_PERIOD:  per = data[TIME_BITS-1:0];
        default: ;
      endcase
    endfunction

    // from + (to - from) * num / den, quotient truncated toward zero
    function longint slope(longint from, longint to, longint unsigned num,
                           longint unsigned den);
      longint diff;
      longint unsigned mag, q;
      diff = to - from;
      mag = diff < 0 ? -diff : diff;
      q = (mag * num) / den;
      return diff < 0 ? from - longint'(q) : from + longint'(q);
    endfunction

    function logic signed [LEVEL_BITS-1:0] level_at(logic [TIME_BITS-1:0] t);
      longint unsigned phase, top_end, fall_end;
      longint lvl;
      top_end = longint'(rise) + longint'(wid);
      fall_end = top_end + longint'(fall);
      if (t < dly) begin
        lvl = init_lvl;
      end else begin
        phase = t - dly;
        if (per != 0) phase = phase % per;
        if (phase < rise) lvl = slope(init_lvl, pulse_lvl, phase, rise);
        else if (phase < top_end) lvl = pulse_lvl;
        else if (phase < fall_end) lvl = slope(pulse_lvl, init_lvl, phase - top_end, fall);
        else lvl = init_lvl;
      end
      return lvl[LEVEL_BITS-1:0];
    endfunction

    function void note_word(logic [TIME_BITS-1:0] t);
      expected_levels.push_back(level_at(t));
      words++;
    endfunction

    function void check_level(logic signed [LEVEL_BITS-1:0] got);
      logic signed [LEVEL_BITS-1:0] want;
      results++;
      if (expected_levels.size() == 0) begin
        $error("level: unexpected result %0d", got);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        $error("level: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TIME_BITS-1:0] in_time_ticks = '0;
  logic out_valid;
  logic signed [LEVEL_BITS-1:0] out_level;
  logic cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  level_scoreboard sb = new();
  int cycles = 0;
  int settings = 0;

  trapezoid_pulse_waveform_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted words and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_word(in_time_ticks);
    if (rst_n && out_valid) sb.check_level(out_level);
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** trapezoid_pulse_waveform_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold start high across back-to-back words; drop it only for a gap
  task automatic send_word(logic [TIME_BITS-1:0] t, int idle_pct);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    start <= 1'b1;
    in_time_ticks <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Wait for every expected level, then for the pipeline to empty
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_setting(int init_v, int pulse_v, logic [31:0] d, logic [31:0] r,
                              logic [31:0] f, logic [31:0] w, logic [31:0] p);
    drain();
    // junk in the upper bits of level writes must be ignored
    write_reg(REG_INITIAL, {16'($urandom), init_v[15:0]});
    write_reg(REG_PULSE, {16'($urandom), pulse_v[15:0]});
    write_reg(REG_DELAY, d);
    write_reg(REG_RISE, r);
    write_reg(REG_FALL, f);
    write_reg(REG_WIDTH, w);
    write_reg(REG_PERIOD, p);
    write_reg(IDX_UNUSED, $urandom);
    settings++;
  endtask

  // Times clustered near pulse edges, with some fully random
  function automatic logic [TIME_BITS-1:0] pick_time();
    logic [TIME_BITS-1:0] base, off;
    logic [TIME_BITS-1:0] span;
    if ($urandom_range(9) == 0) return $urandom;
    base = sb.dly + sb.per * $urandom_range(3);
    span = sb.rise + sb.wid + sb.fall;
    case ($urandom_range(4))
      0: off = sb.rise + $urandom_range(2) - 1;
      1: off = sb.rise + sb.wid + $urandom_range(2) - 1;
      2: off = span + $urandom_range(2) - 1;
      3: off = -$urandom_range(3);
      default: off = (span < 1000) ? $urandom_range(span + 4) : $urandom;
    endcase
    return base + off;
  endfunction

  function automatic logic [31:0] pick_dur();
    case ($urandom_range(7))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  initial begin
    int n, idle;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset registers, then a normal repeating pulse
    send_word(32'd0, 0);
    send_word(32'hFFFF_FFFF, 0);
    load_setting(-100, 1000, 10, 8, 4, 5, 30);
    send_word(32'd0, 0); send_word(32'd9, 0); send_word(32'd10, 0);
    send_word(32'd13, 0); send_word(32'd18, 0); send_word(32'd22, 0);
    send_word(32'd23, 0); send_word(32'd25, 0); send_word(32'd27, 0);
    send_word(32'd41, 0); send_word(32'hFFFF_FFFF, 0);
    // Zero period: single pulse, then initial level forever
    load_setting(500, -700, 0, 3, 3, 2, 0);
    send_word(32'd7, 0); send_word(32'd8, 0); send_word(32'd5000, 0);
    // Zero ramps: steps, and a period shorter than the pulse
    load_setting(-32768, 32767, 2, 0, 0, 4, 3);
    send_word(32'd2, 0); send_word(32'd5, 0); send_word(32'd1, 0);
    // Widest levels and durations, sums past the time width
    load_setting(32767, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 0); send_word(32'hFFFF_FFFF, 0);
    load_setting(32767, -32768, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_word(32'h8000_0000, 0); send_word(32'hFFFF_FFFF, 0);

    // Random settings, each followed by a batch of words
    n = 0;
    while (n < 1850) begin
      if ($urandom_range(5) == 0)
        load_setting($urandom_range(1) ? -32768 : 32767, $urandom, pick_dur(), pick_dur(),
                     pick_dur(), pick_dur(), pick_dur());
      else
        load_setting($urandom, $urandom, $urandom_range(50), pick_dur(), pick_dur(),
                     pick_dur(), $urandom_range(3) == 0 ? 0 : $urandom_range(120));
      repeat ($urandom_range(90, 30)) begin
        idle = (n < 620) ? 38 : (n < 1240) ? 49 : 0;
        send_word(pick_time(), idle);
        n++;
      end
    end
    drain();

    $display("run covered %0d words, %0d levels checked, %0d register settings",
             sb.words, sb.results, settings);
    if (sb.errors == 0 && sb.expected_levels.size() == 0)
      $display("** trapezoid_pulse_waveform_top: PASSED **");
    else
      $display("** trapezoid_pulse_waveform_top: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/trap_pkg.sv
design/trapezoid_pulse_waveform_top.sv
design/trap_checker.sv
test/tb_top.sv
